@@ rtl/core/emg_proportional_motor_command_defines.svh @@
// assertion macros shared by the rtl
`ifndef EMG_PROPORTIONAL_MOTOR_COMMAND_DEFINES_SVH
`define EMG_PROPORTIONAL_MOTOR_COMMAND_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define EPMC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EPMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/epmc_pkg.sv @@
package epmc_pkg;

    localparam int CfgDataW  = 24;
    localparam int CfgIndexW = 3;
    localparam int CfgLimitW = 12;
    localparam int GainW     = 24;
    localparam int CurrentW  = 16;
    localparam int ThrW      = 15;
    localparam int CountW    = 16;
    localparam int CmdW      = 16;
    localparam int GainShift = 16;

    localparam int ResetMin     = 200;
    localparam int ResetMax     = 3000;
    localparam int ResetGain    = 65536;
    localparam int ResetCurrent = 2000;
    localparam int ResetTicks   = 100;

    typedef enum logic [CfgIndexW-1:0] {
        REG_CLOSE_MIN      = 3'd0,
        REG_CLOSE_MAX      = 3'd1,
        REG_OPEN_MIN       = 3'd2,
        REG_OPEN_MAX       = 3'd3,
        REG_CLOSE_GAIN     = 3'd4,
        REG_OPEN_GAIN      = 3'd5,
        REG_CUTOUT_CURRENT = 3'd6,
        REG_CUTOUT_TICKS   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic              active;
        logic [CountW-1:0] count;
        logic              last_dir;
    } cutout_state_t;

endpackage

@@ rtl/core/epmc_if.sv @@
interface epmc_in_if #(
    parameter int EMG_BITS = 12
) ();
    logic                                valid;
    logic                                ready;
    logic [EMG_BITS-1:0]                 emg_open_level;
    logic [EMG_BITS-1:0]                 emg_close_level;
    logic signed [epmc_pkg::CurrentW-1:0] motor_current;

    modport source (
        output valid, emg_open_level, emg_close_level, motor_current,
        input  ready
    );
    modport sink (
        input  valid, emg_open_level, emg_close_level, motor_current,
        output ready
    );
endinterface

interface epmc_out_if ();
    logic                        valid;
    logic                        ready;
    logic [epmc_pkg::CmdW-1:0]   speed_command;
    logic                        close_direction;
    logic                        in_cutout;

    modport source (
        output valid, speed_command, close_direction, in_cutout,
        input  ready
    );
    modport sink (
        input  valid, speed_command, close_direction, in_cutout,
        output ready
    );
endinterface

@@ rtl/core/emg_proportional_motor_command.sv @@
// channel       | dir | beat contents
// sample_in     | in  | emg_open_level, emg_close_level, motor_current
// command_out   | out | speed_command, close_direction, in_cutout
// cfg port      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// one beat per cycle sustained while command_out is ready; each beat passes the input register then the result register
// the whole tick (clamp, 24-bit gain multiply, cutout update) sits between those registers
// reset clears valids, cutout state and restores register defaults; no clearing pass
// a stalled result holds its register while one more beat waits in the input register
`include "emg_proportional_motor_command_defines.svh"

module emg_proportional_motor_command #(
    parameter int EMG_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    epmc_in_if.sink                           sample_in,
    epmc_out_if.source                        command_out,
    input  logic                              cfg_we,
    input  logic [epmc_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [epmc_pkg::CfgDataW-1:0]     cfg_data
);

    localparam int LimCfgW = (EMG_BITS < epmc_pkg::CfgLimitW) ? EMG_BITS : epmc_pkg::CfgLimitW;
    localparam int LevelMax = (1 << EMG_BITS) - 1;
    localparam logic [EMG_BITS-1:0] MinReset =
        EMG_BITS'((epmc_pkg::ResetMin > LevelMax) ? LevelMax : epmc_pkg::ResetMin);
    localparam logic [EMG_BITS-1:0] MaxReset =
        EMG_BITS'((epmc_pkg::ResetMax > LevelMax) ? LevelMax : epmc_pkg::ResetMax);

    // configuration
    logic [EMG_BITS-1:0]             close_min_reg;
    logic [EMG_BITS-1:0]             close_max_reg;
    logic [EMG_BITS-1:0]             open_min_reg;
    logic [EMG_BITS-1:0]             open_max_reg;
    logic [epmc_pkg::GainW-1:0]      close_gain_reg;
    logic [epmc_pkg::GainW-1:0]      open_gain_reg;
    logic [epmc_pkg::ThrW-1:0]       cutout_current_reg;
    logic [epmc_pkg::CountW-1:0]     cutout_ticks_reg;

    // input stage
    logic                            s1_valid_reg;
    logic [EMG_BITS-1:0]             s1_open_reg;
    logic [EMG_BITS-1:0]             s1_close_reg;
    logic [epmc_pkg::CurrentW-1:0]   s1_current_reg;

    // result stage
    logic                            out_valid_reg;
    logic [epmc_pkg::CmdW-1:0]       speed_reg;
    logic                            dir_reg;
    logic                            cutout_flag_reg;

    epmc_pkg::cutout_state_t         state_reg;
    epmc_pkg::cutout_state_t         state_next;

    logic                            advance;
    logic [epmc_pkg::CmdW-1:0]       close_cmd;
    logic [epmc_pkg::CmdW-1:0]       open_cmd;
    logic                            engaged;
    logic                            dir;
    logic [epmc_pkg::CmdW-1:0]       speed_raw;
    logic [epmc_pkg::CmdW-1:0]       speed_next;
    logic signed [epmc_pkg::CurrentW:0] cur_ext;
    logic [epmc_pkg::CurrentW:0]     cur_mag;
    logic                            over_current;

    assign advance           = s1_valid_reg && (!out_valid_reg || command_out.ready);
    assign sample_in.ready   = !s1_valid_reg || advance;

    assign command_out.valid           = out_valid_reg;
    assign command_out.speed_command   = speed_reg;
    assign command_out.close_direction = dir_reg;
    assign command_out.in_cutout       = cutout_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_min_reg      <= MinReset;
            close_max_reg      <= MaxReset;
            open_min_reg       <= MinReset;
            open_max_reg       <= MaxReset;
            close_gain_reg     <= epmc_pkg::GainW'(epmc_pkg::ResetGain);
            open_gain_reg      <= epmc_pkg::GainW'(epmc_pkg::ResetGain);
            cutout_current_reg <= epmc_pkg::ThrW'(epmc_pkg::ResetCurrent);
            cutout_ticks_reg   <= epmc_pkg::CountW'(epmc_pkg::ResetTicks);
        end
        else if (cfg_we)
        begin
            case (epmc_pkg::cfg_reg_t'(cfg_index))
                epmc_pkg::REG_CLOSE_MIN:      close_min_reg  <= EMG_BITS'(cfg_data[LimCfgW-1:0]);
                epmc_pkg::REG_CLOSE_MAX:      close_max_reg  <= EMG_BITS'(cfg_data[LimCfgW-1:0]);
                epmc_pkg::REG_OPEN_MIN:       open_min_reg   <= EMG_BITS'(cfg_data[LimCfgW-1:0]);
                epmc_pkg::REG_OPEN_MAX:       open_max_reg   <= EMG_BITS'(cfg_data[LimCfgW-1:0]);
                epmc_pkg::REG_CLOSE_GAIN:     close_gain_reg <= cfg_data[epmc_pkg::GainW-1:0];
                epmc_pkg::REG_OPEN_GAIN:      open_gain_reg  <= cfg_data[epmc_pkg::GainW-1:0];
                epmc_pkg::REG_CUTOUT_CURRENT:
                    cutout_current_reg <= cfg_data[epmc_pkg::ThrW-1:0];
                epmc_pkg::REG_CUTOUT_TICKS:
                    cutout_ticks_reg <= cfg_data[epmc_pkg::CountW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            s1_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            s1_open_reg    <= sample_in.emg_open_level;
            s1_close_reg   <= sample_in.emg_close_level;
            s1_current_reg <= sample_in.motor_current;
        end
    end

    epmc_channel_speed #(
        .EMG_BITS (EMG_BITS)
    ) u_close_speed (
        .level (s1_close_reg),
        .lo    (close_min_reg),
        .hi    (close_max_reg),
        .gain  (close_gain_reg),
        .speed (close_cmd)
    );

    epmc_channel_speed #(
        .EMG_BITS (EMG_BITS)
    ) u_open_speed (
        .level (s1_open_reg),
        .lo    (open_min_reg),
        .hi    (open_max_reg),
        .gain  (open_gain_reg),
        .speed (open_cmd)
    );

    always_comb
    begin
        engaged   = !((s1_close_reg < close_min_reg) && (s1_open_reg < open_min_reg));
        dir       = engaged ? (s1_close_reg > s1_open_reg) : state_reg.last_dir;
        speed_raw = '0;
        if (engaged)
        begin
            speed_raw = (s1_close_reg > s1_open_reg) ? close_cmd : open_cmd;
        end

        cur_ext      = (epmc_pkg::CurrentW + 1)'(signed'(s1_current_reg));
        cur_mag      = cur_ext[epmc_pkg::CurrentW] ? (epmc_pkg::CurrentW + 1)'(-cur_ext)
                                                   : (epmc_pkg::CurrentW + 1)'(cur_ext);
        over_current = cur_mag > (epmc_pkg::CurrentW + 1)'(cutout_current_reg);

        state_next          = state_reg;
        state_next.last_dir = dir;
        if (!state_reg.active)
        begin
            if (over_current)
            begin
                state_next.active = 1'b1;
                state_next.count  = '0;
            end
        end
        else if ((state_reg.count >= cutout_ticks_reg) || (dir != state_reg.last_dir))
        begin
            state_next.active = 1'b0;
        end

        speed_next = speed_raw;
        if (state_next.active)
        begin
            speed_next = '0;
            if (state_next.count != {epmc_pkg::CountW{1'b1}})
            begin
                state_next.count = state_next.count + epmc_pkg::CountW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (command_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            speed_reg       <= speed_next;
            dir_reg         <= dir;
            cutout_flag_reg <= state_next.active;
        end
    end

    `EPMC_ASSERT_NOW(a_cutout_zero, out_valid_reg && cutout_flag_reg, speed_reg == '0,
        "cutout beat with nonzero speed")
    `EPMC_ASSERT_NEXT(a_entry_count, advance && !state_reg.active && state_next.active,
        state_reg.count == epmc_pkg::CountW'(1), "cutout entry count not one")
    `EPMC_ASSERT_NEXT(a_limit_exit,
        advance && state_reg.active && (state_reg.count >= cutout_ticks_reg),
        !state_reg.active, "cutout did not end at tick limit")
    `EPMC_ASSERT_NEXT(a_hold_state, !advance, $stable(state_reg),
        "cutout state moved without a beat")

endmodule

@@ rtl/core/epmc_channel_speed.sv @@
module epmc_channel_speed #(
    parameter int EMG_BITS = 12
) (
    input  logic [EMG_BITS-1:0]           level,
    input  logic [EMG_BITS-1:0]           lo,
    input  logic [EMG_BITS-1:0]           hi,
    input  logic [epmc_pkg::GainW-1:0]    gain,
    output logic [epmc_pkg::CmdW-1:0]     speed
);

    localparam int ProdW  = EMG_BITS + epmc_pkg::GainW;
    localparam int ShiftW = ProdW - epmc_pkg::GainShift;

    logic [EMG_BITS-1:0] limited;
    logic [EMG_BITS-1:0] raised;
    logic [EMG_BITS-1:0] span;
    logic [ProdW-1:0]    prod;
    logic [ShiftW-1:0]   scaled;

    // limit to max first, then raise to min
    always_comb
    begin
        limited = (level > hi) ? hi : level;
        raised  = (limited < lo) ? lo : limited;
        span    = raised - lo;
        prod    = ProdW'(span) * ProdW'(gain);
        scaled  = prod[ProdW-1:epmc_pkg::GainShift];
        if (scaled > ShiftW'({epmc_pkg::CmdW{1'b1}}))
        begin
            speed = '1;
        end
        else
        begin
            speed = scaled[epmc_pkg::CmdW-1:0];
        end
    end

endmodule

@@ dv/tb_emg_proportional_motor_command.sv @@
`timescale 1ns / 100ps

module tb_emg_proportional_motor_command;

    localparam int EMG_BITS   = 12;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_BEATS = 60;
    localparam int SETTLE     = 4;

    typedef struct packed {
        logic [EMG_BITS-1:0]                  open_lv;
        logic [EMG_BITS-1:0]                  close_lv;
        logic signed [epmc_pkg::CurrentW-1:0] current;
    } sample_t;

    typedef struct packed {
        logic [epmc_pkg::CmdW-1:0] speed;
        logic                      close_dir;
        logic                      cutout;
    } command_t;

    logic clk;
    logic rst_n;
    logic                           cfg_we;
    logic [epmc_pkg::CfgIndexW-1:0] cfg_index;
    logic [epmc_pkg::CfgDataW-1:0]  cfg_data;

    epmc_in_if #(.EMG_BITS(EMG_BITS)) sample_if ();
    epmc_out_if                       command_if ();

    emg_proportional_motor_command #(
        .EMG_BITS (EMG_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_in   (sample_if),
        .command_out (command_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // register copies
    logic [EMG_BITS-1:0] close_min_r = EMG_BITS'(epmc_pkg::ResetMin);
    logic [EMG_BITS-1:0] close_max_r = EMG_BITS'(epmc_pkg::ResetMax);
    logic [EMG_BITS-1:0] open_min_r  = EMG_BITS'(epmc_pkg::ResetMin);
    logic [EMG_BITS-1:0] open_max_r  = EMG_BITS'(epmc_pkg::ResetMax);
    logic [epmc_pkg::GainW-1:0]  close_gain_r   = epmc_pkg::GainW'(epmc_pkg::ResetGain);
    logic [epmc_pkg::GainW-1:0]  open_gain_r    = epmc_pkg::GainW'(epmc_pkg::ResetGain);
    logic [epmc_pkg::ThrW-1:0]   trip_current_r = epmc_pkg::ThrW'(epmc_pkg::ResetCurrent);
    logic [epmc_pkg::CountW-1:0] trip_ticks_r   = epmc_pkg::CountW'(epmc_pkg::ResetTicks);

    // motor state copy
    logic                        trip_active = 1'b0;
    logic [epmc_pkg::CountW-1:0] trip_count  = '0;
    logic                        prev_dir    = 1'b0;

    sample_t  pending_samples[$];
    command_t expected_commands[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_arm = 1'b0;
    bit rx_hold_taken = 1'b0;
    int rx_hold_left = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int commands_seen = 0;
    int cutout_seen = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [epmc_pkg::CmdW-1:0] channel_speed(
        logic [EMG_BITS-1:0]        lvl,
        logic [EMG_BITS-1:0]        lo,
        logic [EMG_BITS-1:0]        hi,
        logic [epmc_pkg::GainW-1:0] gain);
        logic [EMG_BITS-1:0] v;
        logic [39:0]         prod;
        v = lvl;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        prod = 40'(v - lo) * 40'(gain);
        prod = prod >> epmc_pkg::GainShift;
        if (prod > 40'hFFFF)
            return '1;
        return prod[epmc_pkg::CmdW-1:0];
    endfunction

    task automatic predict_command(sample_t s);
        command_t                  exp_cmd;
        logic [epmc_pkg::CmdW-1:0] speed;
        logic [epmc_pkg::CmdW-1:0] close_cmd;
        logic [epmc_pkg::CmdW-1:0] open_cmd;
        logic                      dir;
        int                        cur;
        int                        thr;
        speed = '0;
        dir   = prev_dir;
        if (!(s.close_lv < close_min_r && s.open_lv < open_min_r))
        begin
            close_cmd = '0;
            open_cmd  = '0;
            if (s.close_lv >= close_min_r)
                close_cmd = channel_speed(s.close_lv, close_min_r, close_max_r, close_gain_r);
            if (s.open_lv >= open_min_r)
                open_cmd = channel_speed(s.open_lv, open_min_r, open_max_r, open_gain_r);
            if (s.close_lv > s.open_lv)
            begin
                speed = close_cmd;
                dir   = 1'b1;
            end
            else
            begin
                speed = open_cmd;
                dir   = 1'b0;
            end
        end
        cur = int'($signed(s.current));
        thr = int'(trip_current_r);
        if (!trip_active)
        begin
            if (cur > thr || cur < -thr)
            begin
                trip_active = 1'b1;
                trip_count  = '0;
            end
        end
        else if (trip_count >= trip_ticks_r || dir != prev_dir)
        begin
            trip_active = 1'b0;
        end
        if (trip_active)
        begin
            speed = '0;
            if (trip_count != '1)
                trip_count = trip_count + epmc_pkg::CountW'(1);
        end
        prev_dir = dir;
        exp_cmd.speed     = speed;
        exp_cmd.close_dir = dir;
        exp_cmd.cutout    = trip_active;
        expected_commands.push_back(exp_cmd);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        sample_t nxt;
        if (!rst_n)
        begin
            sample_if.valid <= 1'b0;
        end
        else
        begin
            if (sample_if.valid && sample_if.ready)
            begin
                nxt.open_lv  = sample_if.emg_open_level;
                nxt.close_lv = sample_if.emg_close_level;
                nxt.current  = sample_if.motor_current;
                predict_command(nxt);
                samples_sent++;
            end
            if (!sample_if.valid || sample_if.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = pending_samples.pop_front();
                    sample_if.valid           <= 1'b1;
                    sample_if.emg_open_level  <= nxt.open_lv;
                    sample_if.emg_close_level <= nxt.close_lv;
                    sample_if.motor_current   <= nxt.current;
                end
                else
                begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_arm && !rx_hold_taken)
        begin
            rx_hold_taken <= 1'b1;
            rx_hold_left  <= HOLD_BEATS;
        end
    end

    // command monitor
    always @(posedge clk)
    begin
        command_t got;
        command_t want;
        if (!rst_n)
        begin
            command_if.ready <= 1'b0;
        end
        else
        begin
            if (command_if.valid && command_if.ready)
            begin
                got.speed     = command_if.speed_command;
                got.close_dir = command_if.close_direction;
                got.cutout    = command_if.in_cutout;
                commands_seen++;
                if (got.cutout)
                    cutout_seen++;
                if (expected_commands.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected command beat, actual speed=%0d dir=%0b cutout=%0b",
                             $time, got.speed, got.close_dir, got.cutout);
                end
                else
                begin
                    want = expected_commands.pop_front();
                    if (got.speed !== want.speed)
                    begin
                        mismatches++;
                        $display("%0t: speed_command expected %0d actual %0d",
                                 $time, want.speed, got.speed);
                    end
                    if (got.close_dir !== want.close_dir)
                    begin
                        mismatches++;
                        $display("%0t: close_direction expected %0b actual %0b",
                                 $time, want.close_dir, got.close_dir);
                    end
                    if (got.cutout !== want.cutout)
                    begin
                        mismatches++;
                        $display("%0t: in_cutout expected %0b actual %0b",
                                 $time, want.cutout, got.cutout);
                    end
                end
            end
            if (rx_hold_left > 0)
            begin
                command_if.ready <= 1'b0;
            end
            else
            begin
                command_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_sample(int open_lv, int close_lv, int current);
        sample_t s;
        s.open_lv  = open_lv[EMG_BITS-1:0];
        s.close_lv = close_lv[EMG_BITS-1:0];
        s.current  = current[epmc_pkg::CurrentW-1:0];
        pending_samples.push_back(s);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_commands.size() != 0
               || sample_if.valid)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(epmc_pkg::cfg_reg_t idx, logic [epmc_pkg::CfgDataW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            epmc_pkg::REG_CLOSE_MIN:      close_min_r    = val[EMG_BITS-1:0];
            epmc_pkg::REG_CLOSE_MAX:      close_max_r    = val[EMG_BITS-1:0];
            epmc_pkg::REG_OPEN_MIN:       open_min_r     = val[EMG_BITS-1:0];
            epmc_pkg::REG_OPEN_MAX:       open_max_r     = val[EMG_BITS-1:0];
            epmc_pkg::REG_CLOSE_GAIN:     close_gain_r   = val[epmc_pkg::GainW-1:0];
            epmc_pkg::REG_OPEN_GAIN:      open_gain_r    = val[epmc_pkg::GainW-1:0];
            epmc_pkg::REG_CUTOUT_CURRENT: trip_current_r = val[epmc_pkg::ThrW-1:0];
            epmc_pkg::REG_CUTOUT_TICKS:   trip_ticks_r   = val[epmc_pkg::CountW-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(int cmin, int cmax, int omin, int omax,
                                 int cgain, int ogain, int trip_cur, int trip_ticks);
        write_reg(epmc_pkg::REG_CLOSE_MIN, epmc_pkg::CfgDataW'(cmin));
        write_reg(epmc_pkg::REG_CLOSE_MAX, epmc_pkg::CfgDataW'(cmax));
        write_reg(epmc_pkg::REG_OPEN_MIN, epmc_pkg::CfgDataW'(omin));
        write_reg(epmc_pkg::REG_OPEN_MAX, epmc_pkg::CfgDataW'(omax));
        write_reg(epmc_pkg::REG_CLOSE_GAIN, epmc_pkg::CfgDataW'(cgain));
        write_reg(epmc_pkg::REG_OPEN_GAIN, epmc_pkg::CfgDataW'(ogain));
        write_reg(epmc_pkg::REG_CUTOUT_CURRENT, epmc_pkg::CfgDataW'(trip_cur));
        write_reg(epmc_pkg::REG_CUTOUT_TICKS, epmc_pkg::CfgDataW'(trip_ticks));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int pick_level(int lo_lim);
        case ($urandom_range(5))
            0:       return 0;
            1:       return (1 << EMG_BITS) - 1;
            2:       return (lo_lim + $urandom_range(3) > 4095) ? 4095 : lo_lim + $urandom_range(3);
            default: return $urandom_range((1 << EMG_BITS) - 1);
        endcase
    endfunction

    task automatic queue_random(int n);
        int dom_close;
        int pick;
        int lead_lv;
        int trail_lv;
        int open_lv;
        int close_lv;
        int cur;
        int mag;
        int thr;
        dom_close = $urandom_range(1);
        thr = int'(trip_current_r);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(24) == 0)
                dom_close = !dom_close;
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                open_lv  = (open_min_r == 0) ? 0 : $urandom_range(int'(open_min_r) - 1);
                close_lv = (close_min_r == 0) ? 0 : $urandom_range(int'(close_min_r) - 1);
            end
            else if (pick < 18)
            begin
                open_lv  = $urandom_range(4095);
                close_lv = $urandom_range(4095);
            end
            else
            begin
                lead_lv  = pick_level(dom_close ? int'(close_min_r) : int'(open_min_r));
                trail_lv = ($urandom_range(9) == 0) ? lead_lv : $urandom_range(lead_lv);
                open_lv  = dom_close ? trail_lv : lead_lv;
                close_lv = dom_close ? lead_lv : trail_lv;
            end
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                mag = $urandom_range(32768, thr + 1);
                cur = (mag == 32768 || $urandom_range(1)) ? -mag : mag;
            end
            else if (pick < 14)
            begin
                cur = $signed(16'($urandom));
            end
            else
            begin
                cur = $urandom_range(thr);
                if ($urandom_range(1))
                    cur = -cur;
            end
            push_sample(open_lv, close_lv, cur);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.emg_open_level = '0;
        sample_if.emg_close_level = '0;
        sample_if.motor_current = '0;
        command_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 14;
        rx_idle_pct = 69;
        // reset settings, edge cases and cutout entry and exit
        push_sample(0, 0, 0);
        push_sample(4095, 0, 0);
        push_sample(0, 4095, 0);
        push_sample(1000, 1000, 0);
        push_sample(0, 200, 0);
        push_sample(199, 199, 0);
        push_sample(0, 1500, 2000);
        push_sample(0, 1500, 2001);
        push_sample(0, 1600, -32768);
        push_sample(100, 100, 0);
        push_sample(3000, 0, 0);
        push_sample(3000, 0, -2001);
        push_sample(3000, 0, 32767);
        push_sample(0, 3000, 0);
        push_sample(0, 3000, -2000);
        push_sample(4095, 4095, -32768);
        push_sample(4095, 4095, 0);
        push_sample(12'hAAA, 12'h555, 16'h5555);
        push_sample(12'h555, 12'hAAA, 0);
        push_sample(0, 0, 32767);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            tx_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 69 : 0;
            rx_idle_pct = (phase < 2) ? 69 : (phase < 4) ? 14 : 0;
            case (phase)
                0: load_settings(0, 4095, 0, 4095, 24'h010000, 24'h008000, 15'h7FFF, 0);
                1: load_settings(4095, 0, 4095, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 16'hFFFF);
                2: load_settings($urandom_range(800, 100), $urandom_range(4095, 1500),
                                 $urandom_range(800, 100), $urandom_range(4095, 1500),
                                 $urandom_range(24'h3FFFF), $urandom_range(24'h3FFFF),
                                 $urandom_range(3000, 300), $urandom_range(12, 1));
                3: load_settings(epmc_pkg::ResetMin, epmc_pkg::ResetMax,
                                 epmc_pkg::ResetMin, epmc_pkg::ResetMax,
                                 epmc_pkg::ResetGain, epmc_pkg::ResetGain,
                                 epmc_pkg::ResetCurrent, epmc_pkg::ResetTicks);
                4: load_settings($urandom_range(4095), $urandom_range(4095),
                                 $urandom_range(4095), $urandom_range(4095),
                                 $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                                 $urandom_range(4000), $urandom_range(5));
                default: load_settings(4095, 4095, 0, 0, 0, 1, 1, 1);
            endcase
            queue_random(250);
            if (phase == 4)
                rx_hold_arm = 1'b1;
            drain();
        end

        $display("%0d samples and %0d commands checked, %0d in cutout", samples_sent,
                 commands_seen, cutout_seen);
        $display("covered seven register settings, three idling patterns and a long stall");
        if (mismatches == 0 && expected_commands.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/epmc_pkg.sv
rtl/core/epmc_if.sv
rtl/core/epmc_channel_speed.sv
rtl/core/emg_proportional_motor_command.sv
dv/tb_emg_proportional_motor_command.sv
